[src/dadsr_envelope_generator_macros.svh]
// Assertion macros for the DADSR envelope generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define DADSR_ENVELOPE_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define DADSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dadsr envelope check failed");
// Check that cons holds in the cycle after ante.
`define DADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dadsr envelope check failed");
`else
`define DADSR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/dadsr_pkg.sv]
// Shared types and constants for the DADSR envelope generator.
// No dependencies; imported by the multiply-divide unit and the top level.
`default_nettype none
package dadsr_pkg;

    typedef logic [2:0] stage_t;

    localparam stage_t ST_IDLE    = 3'd0;
    localparam stage_t ST_DELAY   = 3'd1;
    localparam stage_t ST_ATTACK  = 3'd2;
    localparam stage_t ST_DECAY   = 3'd3;
    localparam stage_t ST_SUSTAIN = 3'd4;
    localparam stage_t ST_RELEASE = 3'd5;

    localparam int CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_DELAY   = 3'd0;
    localparam cfg_index_t REG_ATTACK  = 3'd1;
    localparam cfg_index_t REG_DECAY   = 3'd2;
    localparam cfg_index_t REG_SUSTAIN = 3'd3;
    localparam cfg_index_t REG_RELEASE = 3'd4;
    localparam cfg_index_t REG_ENABLE  = 3'd5;

    localparam int DELAY_RESET   = 11025;
    localparam int ATTACK_RESET  = 22050;
    localparam int DECAY_RESET   = 22050;
    localparam int SUSTAIN_RESET = 49151;
    localparam int RELEASE_RESET = 4410;

    // Phases of the serial multiply-divide unit
    typedef logic [1:0] md_phase_t;

    localparam md_phase_t MD_IDLE = 2'd0;
    localparam md_phase_t MD_MUL  = 2'd1;
    localparam md_phase_t MD_DIV  = 2'd2;

endpackage
`default_nettype wire

[src/dadsr_muldiv.sv]
// Bit-serial unit: quot = floor(mcand * mplier / divisor), one bit per cycle.
// Uses dadsr_pkg for its phase codes. Requires mcand <= divisor, divisor nonzero.
`default_nettype none
module dadsr_muldiv
    import dadsr_pkg::*;
#(
    parameter int COUNT_WIDTH = 20,
    parameter int LEVEL_WIDTH = 16
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] mcand,
    input  logic [LEVEL_WIDTH-1:0] mplier,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [LEVEL_WIDTH-1:0] quot
);

    localparam int STEP_W = $clog2(LEVEL_WIDTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LEVEL_WIDTH - 1);

    md_phase_t              phase_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   done_reg;
    logic [COUNT_WIDTH-1:0] hi_reg;
    logic [LEVEL_WIDTH-1:0] lo_reg;
    logic [COUNT_WIDTH-1:0] mcand_reg;
    logic [COUNT_WIDTH-1:0] divisor_reg;

    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   qbit;
    logic [COUNT_WIDTH-1:0] rem_next;

    // Multiply: add mcand under the low multiplier bit, shift right
    assign sum = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? mcand_reg : '0)};

    // Divide: shift next product bit into the remainder, restore on borrow
    assign trial    = {hi_reg, lo_reg[LEVEL_WIDTH-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign qbit     = (trial >= {1'b0, divisor_reg});
    assign rem_next = qbit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= MD_MUL;
                        step_reg  <= '0;
                    end
                end
                MD_MUL:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        phase_reg <= MD_DIV;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                MD_DIV:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        phase_reg <= MD_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= MD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    hi_reg      <= '0;
                    lo_reg      <= mplier;
                    mcand_reg   <= mcand;
                    divisor_reg <= divisor;
                end
            end
            MD_MUL:
            begin
                hi_reg <= sum[COUNT_WIDTH:1];
                lo_reg <= {sum[0], lo_reg[LEVEL_WIDTH-1:1]};
            end
            MD_DIV:
            begin
                hi_reg <= rem_next;
                lo_reg <= {lo_reg[LEVEL_WIDTH-2:0], qbit};
            end
            default:
            begin
                hi_reg <= hi_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule
`default_nettype wire

[src/dadsr_envelope_generator.sv]
// DADSR envelope generator top level: configuration registers, stage sequencer
// and output register. Depends on dadsr_pkg, dadsr_muldiv and the macro header.
//
//   channel   direction  handshake                    payload
//   cfg       in         cfg_wr_en (no wait)          cfg_index, cfg_data
//   in        in         in_valid / in_stall          gate
//   out       out        out_valid / out_stall        level, stage
//
// A ramp tick (attack, decay, release) keeps the input stalled while the
// bit-serial multiply and divide in dadsr_muldiv run, one bit per cycle each;
// any other tick skips the divide. Every tick also waits for a free output
// register. Reset clears the sequencer and restores the register defaults at
// once; there is no clearing pass. A stalled output holds its result while
// the next tick is taken and worked on.
`default_nettype none
`include "dadsr_envelope_generator_macros.svh"
module dadsr_envelope_generator
    import dadsr_pkg::*;
#(
    parameter int COUNT_WIDTH = 20,
    parameter int LEVEL_WIDTH = 16,
    localparam int CFG_WIDTH = (COUNT_WIDTH > LEVEL_WIDTH) ? COUNT_WIDTH : LEVEL_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   gate,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_WIDTH-1:0] level,
    output logic [2:0]             stage
);

    localparam logic [1:0] CTL_READY = 2'd0;
    localparam logic [1:0] CTL_CALC  = 2'd1;
    localparam logic [1:0] CTL_HOLD  = 2'd2;

    localparam logic [LEVEL_WIDTH-1:0] FULL = '1;
    localparam logic [COUNT_WIDTH-1:0] ONE  = COUNT_WIDTH'(1);

    // Configuration registers
    logic [COUNT_WIDTH-1:0] delay_samples_reg;
    logic [COUNT_WIDTH-1:0] attack_samples_reg;
    logic [COUNT_WIDTH-1:0] decay_samples_reg;
    logic [LEVEL_WIDTH-1:0] sustain_level_reg;
    logic [COUNT_WIDTH-1:0] release_samples_reg;
    logic                   enable_reg;

    // Envelope state
    stage_t                 stage_reg, stage_next;
    logic                   gate_prev_reg, gate_prev_next;
    logic [COUNT_WIDTH-1:0] counter_reg, counter_next;
    logic [LEVEL_WIDTH-1:0] last_level_reg;
    logic [LEVEL_WIDTH-1:0] rel_start_reg, rel_start_next;

    // Tick in flight
    logic [1:0]             ctl_state_reg, ctl_state_next;
    stage_t                 pend_stage_reg;
    logic                   pend_use_q_reg;
    logic                   pend_sub_reg;
    logic [LEVEL_WIDTH-1:0] pend_base_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [LEVEL_WIDTH-1:0] level_reg;
    stage_t                 stage_out_reg;

    // Tick decode
    logic                   in_fire;
    logic                   out_free;
    logic [COUNT_WIDTH-1:0] run_len;
    logic                   cnt_less;
    logic [COUNT_WIDTH-1:0] c_clamp;
    logic                   t_arith;
    logic                   t_use_q;
    logic                   t_sub;
    logic [LEVEL_WIDTH-1:0] t_base;
    logic [LEVEL_WIDTH-1:0] t_mplier;
    logic [LEVEL_WIDTH-1:0] level_final;

    logic                   mdu_done;
    logic [LEVEL_WIDTH-1:0] mdu_quot;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (ctl_state_reg != CTL_READY);
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration writes; unknown indexes drop, upper data bits drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg   <= COUNT_WIDTH'(DELAY_RESET);
            attack_samples_reg  <= COUNT_WIDTH'(ATTACK_RESET);
            decay_samples_reg   <= COUNT_WIDTH'(DECAY_RESET);
            sustain_level_reg   <= LEVEL_WIDTH'(SUSTAIN_RESET);
            release_samples_reg <= COUNT_WIDTH'(RELEASE_RESET);
            enable_reg          <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DELAY:   delay_samples_reg   <= cfg_data[COUNT_WIDTH-1:0];
                REG_ATTACK:  attack_samples_reg  <= cfg_data[COUNT_WIDTH-1:0];
                REG_DECAY:   decay_samples_reg   <= cfg_data[COUNT_WIDTH-1:0];
                REG_SUSTAIN: sustain_level_reg   <= cfg_data[LEVEL_WIDTH-1:0];
                REG_RELEASE: release_samples_reg <= cfg_data[COUNT_WIDTH-1:0];
                REG_ENABLE:  enable_reg          <= cfg_data[0];
                default:     enable_reg          <= enable_reg;
            endcase
        end
    end

    // Segment length of the current stage; ramps treat zero as one
    always_comb
    begin
        case (stage_reg)
            ST_DELAY:   run_len = delay_samples_reg;
            ST_ATTACK:  run_len = (attack_samples_reg == '0) ? ONE : attack_samples_reg;
            ST_DECAY:   run_len = (decay_samples_reg == '0) ? ONE : decay_samples_reg;
            ST_RELEASE: run_len = (release_samples_reg == '0) ? ONE : release_samples_reg;
            default:    run_len = ONE;
        endcase
    end

    // Clamp the counter into the segment so a shortened length keeps the level in range
    assign cnt_less = (counter_reg < run_len);
    assign c_clamp  = cnt_less ? counter_reg : run_len;

    // Next envelope state and what the level of this tick is made of
    always_comb
    begin
        stage_next     = stage_reg;
        gate_prev_next = gate_prev_reg;
        counter_next   = counter_reg;
        rel_start_next = rel_start_reg;
        t_arith        = 1'b0;
        t_use_q        = 1'b0;
        t_sub          = 1'b0;
        t_base         = '0;
        t_mplier       = '0;

        if (!enable_reg)
        begin
            stage_next     = ST_IDLE;
            gate_prev_next = 1'b0;
            counter_next   = '0;
            rel_start_next = '0;
        end
        else
        begin
            case (stage_reg)
                ST_IDLE:
                begin
                    counter_next = '0;
                    if (gate != gate_prev_reg)
                    begin
                        gate_prev_next = gate;
                        if (gate)
                        begin
                            stage_next = ST_DELAY;
                        end
                    end
                end
                ST_RELEASE:
                begin
                    // Gate is ignored: ramp down from the captured start level
                    t_arith  = 1'b1;
                    t_use_q  = 1'b1;
                    t_sub    = 1'b1;
                    t_base   = rel_start_reg;
                    t_mplier = rel_start_reg;
                    if (cnt_less)
                    begin
                        counter_next = counter_reg + ONE;
                    end
                    else
                    begin
                        stage_next   = ST_IDLE;
                        counter_next = '0;
                    end
                end
                ST_DELAY, ST_ATTACK, ST_DECAY, ST_SUSTAIN:
                begin
                    if (gate != gate_prev_reg)
                    begin
                        gate_prev_next = gate;
                    end
                    if ((gate != gate_prev_reg) && !gate)
                    begin
                        // Falling gate: hold the last level and capture it once
                        stage_next     = ST_RELEASE;
                        counter_next   = '0;
                        rel_start_next = last_level_reg;
                        t_base         = last_level_reg;
                    end
                    else if (stage_reg == ST_SUSTAIN)
                    begin
                        t_base = sustain_level_reg;
                    end
                    else
                    begin
                        if (stage_reg == ST_ATTACK)
                        begin
                            t_arith  = 1'b1;
                            t_use_q  = 1'b1;
                            t_mplier = FULL;
                        end
                        else if (stage_reg == ST_DECAY)
                        begin
                            t_arith  = 1'b1;
                            t_use_q  = 1'b1;
                            t_sub    = 1'b1;
                            t_base   = FULL;
                            t_mplier = FULL - sustain_level_reg;
                        end
                        if (cnt_less)
                        begin
                            counter_next = counter_reg + ONE;
                        end
                        else
                        begin
                            stage_next   = stage_reg + 3'd1;
                            counter_next = '0;
                        end
                    end
                end
                default:
                begin
                    // Illegal stage code: fall back to idle
                    stage_next     = ST_IDLE;
                    gate_prev_next = 1'b0;
                    counter_next   = '0;
                    rel_start_next = '0;
                end
            endcase
        end
    end

    dadsr_muldiv #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_fire && t_arith),
        .mcand   (c_clamp),
        .mplier  (t_mplier),
        .divisor (run_len),
        .done    (mdu_done),
        .quot    (mdu_quot)
    );

    // Combine the quotient with the segment base
    assign level_final = !pend_use_q_reg ? pend_base_reg :
                         pend_sub_reg    ? (pend_base_reg - mdu_quot) : mdu_quot;

    // Sequencer: take a tick, wait for the divide if the tick needs one, park until the output is free
    always_comb
    begin
        ctl_state_next = ctl_state_reg;
        case (ctl_state_reg)
            CTL_READY:
            begin
                if (in_fire)
                begin
                    ctl_state_next = t_arith ? CTL_CALC : CTL_HOLD;
                end
            end
            CTL_CALC:
            begin
                if (mdu_done)
                begin
                    ctl_state_next = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                if (out_free)
                begin
                    ctl_state_next = CTL_READY;
                end
            end
            default:
            begin
                ctl_state_next = CTL_READY;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((ctl_state_reg == CTL_HOLD) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_state_reg  <= CTL_READY;
            out_valid_reg  <= 1'b0;
            stage_reg      <= ST_IDLE;
            gate_prev_reg  <= 1'b0;
            counter_reg    <= '0;
            last_level_reg <= '0;
            rel_start_reg  <= '0;
        end
        else
        begin
            ctl_state_reg <= ctl_state_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                stage_reg     <= stage_next;
                gate_prev_reg <= gate_prev_next;
                counter_reg   <= counter_next;
                rel_start_reg <= rel_start_next;
            end
            if ((ctl_state_reg == CTL_HOLD) && out_free)
            begin
                last_level_reg <= level_final;
            end
        end
    end

    // Pending tick and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_stage_reg <= stage_next;
            pend_use_q_reg <= t_use_q;
            pend_sub_reg   <= t_sub;
            pend_base_reg  <= t_base;
        end
        if ((ctl_state_reg == CTL_HOLD) && out_free)
        begin
            level_reg     <= level_final;
            stage_out_reg <= pend_stage_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign stage     = stage_out_reg;

    // A transfer on the input closes the input in the next cycle
    `DADSR_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_fire, in_stall)
    // Idle and delay results are always silent
    `DADSR_ASSERT_SAME(a_silent_stages, clk, rst_n,
        out_valid && ((stage == ST_IDLE) || (stage == ST_DELAY)), level == '0)
    // The divide only finishes for a tick that waits on it
    `DADSR_ASSERT_SAME(a_done_in_calc, clk, rst_n, mdu_done, ctl_state_reg == CTL_CALC)

endmodule
`default_nettype wire

[tb/dadsr_envelope_generator_tb.sv]
// Self-checking testbench for dadsr_envelope_generator: drives gate ticks,
// predicts level and stage per tick and checks every output transfer in order.
// Depends on dadsr_pkg and the dadsr_envelope_generator RTL.
`default_nettype none
module dadsr_envelope_generator_tb;
    import dadsr_pkg::*;

    localparam int COUNT_W = 20;
    localparam int LEVEL_W = 16;
    localparam int CFG_W = (COUNT_W > LEVEL_W) ? COUNT_W : LEVEL_W;
    localparam logic [63:0] FULL_SCALE = (64'd1 << LEVEL_W) - 64'd1;
    localparam logic [COUNT_W-1:0] LEN_MAX = '1;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int unsigned RANDOM_PHASES = 12;

    // Indexes beyond the register file; writes to them must be ignored
    localparam cfg_index_t REG_SPARE_LO = 3'd6;
    localparam cfg_index_t REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] lvl;
        stage_t             stg;
    } envelope_point_t;

    // Every input starts at a known value
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    cfg_index_t         cfg_index = REG_DELAY;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               gate = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LEVEL_W-1:0] level;
    logic [2:0]         stage;

    dadsr_envelope_generator #(
        .COUNT_WIDTH (COUNT_W),
        .LEVEL_WIDTH (LEVEL_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .gate      (gate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .stage     (stage)
    );

    always #2 clk = ~clk;

    // Gate ticks waiting to be offered, and envelope points still owed by the DUT
    logic            gate_queue[$];
    envelope_point_t envelope_expect[$];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    logic        hold_go = 1'b0;

    // ------------------------------------------------------------------
    // Envelope predictor: its own copy of the registers and the sequencer
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] set_delay, set_attack, set_decay, set_release;
    logic [LEVEL_W-1:0] set_sustain;
    logic               set_enable;

    stage_t             env_stage;
    logic               env_gate_prev;
    logic [COUNT_W-1:0] env_count;
    logic [LEVEL_W-1:0] env_last;
    logic [LEVEL_W-1:0] env_release_from;

    function automatic void clear_envelope();
        env_stage = ST_IDLE;
        env_gate_prev = 1'b0;
        env_count = '0;
        env_last = '0;
        env_release_from = '0;
    endfunction

    // Ramp lengths of zero behave as one
    function automatic logic [63:0] span_of(input logic [COUNT_W-1:0] len);
        return (len == '0) ? 64'd1 : 64'(len);
    endfunction

    // Clamp the counter into the segment so a shortened stage stays in range
    function automatic logic [63:0] clamp_count(input logic [63:0] span);
        return (64'(env_count) < span) ? 64'(env_count) : span;
    endfunction

    function automatic void advance_stage(input logic [63:0] span, input stage_t next_stage);
        if (64'(env_count) < span)
        begin
            env_count = env_count + 1'b1;
        end
        else
        begin
            env_stage = next_stage;
            env_count = '0;
        end
    endfunction

    function automatic envelope_point_t envelope_tick(input logic g);
        logic [63:0]     span;
        logic [63:0]     pos;
        logic [63:0]     lvl;
        envelope_point_t point;
        lvl = '0;
        if (!set_enable)
        begin
            clear_envelope();
            point.lvl = '0;
            point.stg = ST_IDLE;
            return point;
        end
        if (env_stage == ST_IDLE)
        begin
            env_count = '0;
            if (g != env_gate_prev)
            begin
                env_gate_prev = g;
                if (g)
                    env_stage = ST_DELAY;
            end
        end
        else if (env_stage == ST_RELEASE)
        begin
            // gate is ignored until the ramp reaches zero
            span = span_of(set_release);
            pos = clamp_count(span);
            lvl = 64'(env_release_from) - (pos * 64'(env_release_from)) / span;
            advance_stage(span, ST_IDLE);
        end
        else if (env_stage > ST_RELEASE)
        begin
            clear_envelope();
        end
        else if (g != env_gate_prev && !g)
        begin
            // falling gate: hold the last level and latch it as the release start
            env_gate_prev = g;
            env_stage = ST_RELEASE;
            env_count = '0;
            env_release_from = env_last;
            lvl = 64'(env_last);
        end
        else
        begin
            env_gate_prev = g;
            case (env_stage)
                ST_DELAY:
                begin
                    advance_stage(64'(set_delay), ST_ATTACK);
                end
                ST_ATTACK:
                begin
                    span = span_of(set_attack);
                    pos = clamp_count(span);
                    lvl = (pos * FULL_SCALE) / span;
                    advance_stage(span, ST_DECAY);
                end
                ST_DECAY:
                begin
                    span = span_of(set_decay);
                    pos = clamp_count(span);
                    lvl = FULL_SCALE - (pos * (FULL_SCALE - 64'(set_sustain))) / span;
                    advance_stage(span, ST_SUSTAIN);
                end
                default:
                begin
                    lvl = 64'(set_sustain);
                end
            endcase
        end
        env_last = lvl[LEVEL_W-1:0];
        point.lvl = lvl[LEVEL_W-1:0];
        point.stg = env_stage;
        return point;
    endfunction

    // Track register writes and predict each accepted gate tick
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_delay = COUNT_W'(DELAY_RESET);
            set_attack = COUNT_W'(ATTACK_RESET);
            set_decay = COUNT_W'(DECAY_RESET);
            set_sustain = LEVEL_W'(SUSTAIN_RESET);
            set_release = COUNT_W'(RELEASE_RESET);
            set_enable = 1'b1;
            clear_envelope();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DELAY:   set_delay = cfg_data[COUNT_W-1:0];
                    REG_ATTACK:  set_attack = cfg_data[COUNT_W-1:0];
                    REG_DECAY:   set_decay = cfg_data[COUNT_W-1:0];
                    REG_SUSTAIN: set_sustain = cfg_data[LEVEL_W-1:0];
                    REG_RELEASE: set_release = cfg_data[COUNT_W-1:0];
                    REG_ENABLE:  set_enable = cfg_data[0];
                    default:     ;
                endcase
            end
            if (in_valid && !in_stall)
                envelope_expect.push_back(envelope_tick(gate));
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer the next gate tick once the previous transfer is done
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            // hold valid and payload while stalled; otherwise advance or idle
            if (gate_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                gate <= gate_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only reads it
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_OFF_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random and check each output transfer in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        envelope_point_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_stall_pct);
            if (out_valid && !out_stall)
            begin
                if (envelope_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected output transfer level=%h stage=%0d",
                                 level, stage);
                end
                else
                begin
                    want = envelope_expect.pop_front();
                    if (level !== want.lvl || stage !== want.stg)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: level exp %h got %h, stage exp %0d got %0d",
                                     want.lvl, level, want.stg, stage);
                    end
                end
            end
        end
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every tick was taken and every point came back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (gate_queue.size() != 0 || in_valid || envelope_expect.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Push n gate levels, most significant bit first
    task automatic push_bits(input int n, input logic [31:0] bits);
        for (int i = n - 1; i >= 0; i--)
            gate_queue.push_back(bits[i]);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
        endcase
    endtask

    // Mostly short lengths so envelopes complete; now and then the extremes
    function automatic logic [CFG_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 15);
        case (r)
            0: return '0;
            1: return CFG_W'(LEN_MAX);
            2: return CFG_W'($urandom);
            3: return CFG_W'($urandom_range(13, 300));
            default: return CFG_W'($urandom_range(0, 12));
        endcase
    endfunction

    initial
    begin
        int unsigned pushed;
        int unsigned run_len;
        int unsigned r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short segments: walk every stage, lengths of zero and one,
        // falling gate in delay and in attack, spare indexes ignored
        set_idling(0);
        write_reg(REG_DELAY, CFG_W'(1));
        write_reg(REG_ATTACK, '0);
        write_reg(REG_DECAY, CFG_W'(2));
        write_reg(REG_SUSTAIN, CFG_W'(16'h8000));
        write_reg(REG_RELEASE, '0);
        write_reg(REG_ENABLE, CFG_W'(1));
        write_reg(REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_W'($urandom));
        push_bits(14, 32'b01111111110011);
        push_bits(3, 32'b000);
        push_bits(7, 32'b1111000);
        wait_drained();

        // Longest ramps and full-scale sustain
        write_reg(REG_DELAY, '0);
        write_reg(REG_ATTACK, CFG_W'(LEN_MAX));
        write_reg(REG_DECAY, CFG_W'(LEN_MAX));
        write_reg(REG_SUSTAIN, CFG_W'(16'hFFFF));
        write_reg(REG_RELEASE, CFG_W'(LEN_MAX));
        push_bits(4, 32'b1111);
        wait_drained();

        // Shorten attack while inside it, zero sustain; upper data bits dropped
        write_reg(REG_ATTACK, CFG_W'(2));
        write_reg(REG_RELEASE, CFG_W'(3));
        write_reg(REG_SUSTAIN, CFG_W'(20'hF0000));
        push_bits(7, 32'b1100000);
        wait_drained();

        // Disabled block clears the envelope and outputs zero
        write_reg(REG_ENABLE, CFG_W'(20'hFFFFE));
        push_bits(2, 32'b10);
        wait_drained();
        write_reg(REG_ENABLE, CFG_W'(1));

        // Back-pressure: receiver holds off while the sender keeps offering
        write_reg(REG_DELAY, CFG_W'(2));
        write_reg(REG_ATTACK, CFG_W'(5));
        write_reg(REG_DECAY, CFG_W'(4));
        write_reg(REG_SUSTAIN, CFG_W'($urandom));
        write_reg(REG_RELEASE, CFG_W'(6));
        for (int i = 0; i < 3; i++)
            push_bits(20, 32'b11111111111111000000);
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
        wait_drained();

        // Random phases: new settings, then note-like gate runs with some noise
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_idling(p % 4);
            write_reg(REG_DELAY, pick_length());
            write_reg(REG_ATTACK, pick_length());
            write_reg(REG_DECAY, pick_length());
            r = $urandom_range(0, 5);
            write_reg(REG_SUSTAIN, (r == 0) ? '0 : (r == 1) ? CFG_W'(16'hFFFF) : CFG_W'($urandom));
            write_reg(REG_RELEASE, pick_length());
            write_reg(REG_ENABLE, CFG_W'($urandom_range(0, 7) != 0));
            pushed = 0;
            while (pushed < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    run_len = $urandom_range(1, 8);
                    for (int k = 0; k < run_len; k++)
                        gate_queue.push_back(1'($urandom_range(0, 1)));
                    pushed += run_len;
                end
                else
                begin
                    run_len = $urandom_range(1, 40);
                    for (int k = 0; k < run_len; k++)
                        gate_queue.push_back(1'b1);
                    pushed += run_len;
                    run_len = $urandom_range(1, 12);
                    for (int k = 0; k < run_len; k++)
                        gate_queue.push_back(1'b0);
                    pushed += run_len;
                end
            end
            wait_drained();
        end

        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/dadsr_pkg.sv
src/dadsr_muldiv.sv
src/dadsr_envelope_generator.sv
tb/dadsr_envelope_generator_tb.sv
